// File: hdl/plst_pkg.sv
// Shared types and constants for the positional list store.
package plst_pkg;

  localparam int unsigned DEPTH   = 16;
  localparam int unsigned IdxW    = $clog2(DEPTH);
  localparam int unsigned CntW    = $clog2(DEPTH + 1);
  localparam int unsigned VAL_W   = 31;
  localparam int unsigned POS_W   = 5;
  localparam int unsigned FUNC_W  = 3;
  localparam int unsigned COUNT_W = 5;

  typedef enum logic [FUNC_W-1:0] {
    FN_PUSH   = 3'd0,
    FN_POP    = 3'd1,
    FN_TOP    = 3'd2,
    FN_INSERT = 3'd3,
    FN_GET    = 3'd4,
    FN_REMOVE = 3'd5
  } func_e;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [VAL_W-1:0]  value;
    logic [POS_W-1:0]  position;
  } cmd_t;

  typedef struct packed {
    logic [VAL_W-1:0]   read_value;
    logic               error;
    logic [COUNT_W-1:0] count;
  } result_t;

  // Per-cell update select: load the new value, take the front neighbour's
  // entry (shift towards the back) or take the back neighbour's entry.
  typedef struct packed {
    logic load;
    logic from_front;
    logic from_back;
  } cell_ctl_t;

endpackage

// File: hdl/plst_cell.sv
// One storage cell of the list row, shifting with its neighbours.
module plst_cell
  import plst_pkg::*;
(
  input  logic             clk_i,
  input  cell_ctl_t        ctl_i,
  input  logic [VAL_W-1:0] new_value_i,
  input  logic [VAL_W-1:0] front_value_i,
  input  logic [VAL_W-1:0] back_value_i,
  output logic [VAL_W-1:0] value_o
);

  logic [VAL_W-1:0] value_d, value_q;

  always_comb begin
    value_d = value_q;
    priority if (ctl_i.load) begin
      value_d = new_value_i;
    end else if (ctl_i.from_front) begin
      value_d = front_value_i;
    end else if (ctl_i.from_back) begin
      value_d = back_value_i;
    end else begin
      value_d = value_q;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

// File: hdl/positional_list_store.sv
// Top level of the positional list store: command decode, count and cell row.
//
// Bounded ordered list of up to DEPTH 31-bit values, index zero at the front.
// Command channel: drive cmd_i (func, value, position) and raise start_i; the
// command transfers at the rising edge where start_i is high and busy_o low.
// busy_o is never raised, so a command may be issued in every cycle.
// Result channel: result_o (read_value, error, count) is shown for exactly one
// cycle with done_o high, in the cycle after the command transfers. The receiver
// cannot stall; each result must be taken in the cycle it is shown.
// Throughput is one command per cycle: every insert or remove moves the cells
// at or behind the position in the same clock edge, each taking its neighbour's
// entry or the new value, and reads select one cell through a single mux.
// Rejected commands (full, empty, position out of range, unused code) return
// error with read_value zero and leave the list untouched.
// Reset clears the element count and the result strobe; cell contents are
// left as they are and only entries below the count are ever read.
module positional_list_store
  import plst_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start_i,
  input  cmd_t    cmd_i,
  output logic    busy_o,
  output logic    done_o,
  output result_t result_o
);

  logic [CntW-1:0]  held_d, held_q;
  logic             done_d, done_q;
  result_t          res_d, res_q;
  logic             accept;
  logic [CntW-1:0]  pos;
  logic             pos_le, pos_lt, room;
  logic             do_place, do_take, ok;
  logic [VAL_W-1:0] rd;
  logic [VAL_W-1:0] cell_val [DEPTH];
  cell_ctl_t        cell_ctl [DEPTH];

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  always_comb begin
    unique case (cmd_i.func)
      FN_INSERT, FN_GET, FN_REMOVE: pos = CntW'(cmd_i.position);
      default:                      pos = '0;
    endcase
  end

  assign pos_le = pos <= held_q;
  assign pos_lt = pos < held_q;
  assign room   = held_q < CntW'(DEPTH);

  always_comb begin
    do_place = 1'b0;
    do_take  = 1'b0;
    ok       = 1'b0;
    rd       = '0;
    unique case (cmd_i.func)
      FN_PUSH, FN_INSERT: begin
        do_place = room && pos_le;
        ok       = do_place;
      end
      FN_POP, FN_REMOVE: begin
        do_take = pos_lt;
        ok      = do_take;
      end
      FN_TOP, FN_GET: begin
        ok = pos_lt;
        if (pos_lt) begin
          rd = cell_val[pos[IdxW-1:0]];
        end
      end
      default: ok = 1'b0;
    endcase
  end

  always_comb begin
    held_d = held_q;
    if (accept && do_place) begin
      held_d = held_q + CntW'(1);
    end else if (accept && do_take) begin
      held_d = held_q - CntW'(1);
    end
    done_d           = accept;
    res_d.read_value = rd;
    res_d.error      = !ok;
    res_d.count      = COUNT_W'(held_d);
  end

  // Cells at or behind the position move; on an insert the cell at the position loads.
  for (genvar i = 0; i < DEPTH; i++) begin : g_row
    logic [VAL_W-1:0] front_v, back_v;
    logic             at_or_behind;

    assign at_or_behind = CntW'(i) >= pos;

    always_comb begin
      cell_ctl[i].load       = accept && do_place && (CntW'(i) == pos);
      cell_ctl[i].from_front = accept && do_place && at_or_behind;
      cell_ctl[i].from_back  = accept && do_take && at_or_behind;
    end

    if (i == 0) begin : g_first
      assign front_v = '0;
    end else begin : g_mid
      assign front_v = cell_val[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign back_v = '0;
    end else begin : g_inner
      assign back_v = cell_val[i+1];
    end

    plst_cell u_cell (
      .clk_i         (clk_i),
      .ctl_i         (cell_ctl[i]),
      .new_value_i   (cmd_i.value),
      .front_value_i (front_v),
      .back_value_i  (back_v),
      .value_o       (cell_val[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
      done_q <= 1'b0;
    end else begin
      held_q <= held_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o   = done_q;
  assign result_o = res_q;

  a_held_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= CntW'(DEPTH))
    else $error("element count beyond depth");

  a_one_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> done_o)
    else $error("transferred command produced no result");

  a_err_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.error |-> result_o.read_value == '0)
    else $error("rejected command returned data");

  a_err_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.error |-> held_q == $past(held_q))
    else $error("rejected command changed the count");

endmodule
